FILE: hw/rtl/hgp_pkg.sv
// Package: shared types and item codes for the HID gamepad descriptor parser.
`timescale 1ns / 1ps

package hgp_pkg;

    // Width of the running bit offset; wraps modulo 2**OFFSET_WIDTH (range 8..32)
    localparam int OFFSET_WIDTH = 16;
    localparam int OUT_OFF_W    = 16;

    // Short item size code that stands for four data bytes
    localparam logic [1:0] SIZE_CODE_FOUR = 2'h3;

    // Item types
    localparam logic [1:0] TYPE_MAIN   = 2'd0;
    localparam logic [1:0] TYPE_GLOBAL = 2'd1;
    localparam logic [1:0] TYPE_LOCAL  = 2'd2;

    // Main item tags
    localparam logic [3:0] TAG_INPUT      = 4'h8;
    localparam logic [3:0] TAG_COLLECTION = 4'hA;

    // Global item tags
    localparam logic [3:0] TAG_USAGE_PAGE   = 4'h0;
    localparam logic [3:0] TAG_REPORT_SIZE  = 4'h7;
    localparam logic [3:0] TAG_REPORT_ID    = 4'h8;
    localparam logic [3:0] TAG_REPORT_COUNT = 4'h9;

    // Local item tags
    localparam logic [3:0] TAG_USAGE = 4'h0;

    // Pages and usages of interest
    localparam logic [7:0] PAGE_DESKTOP = 8'h01;
    localparam logic [7:0] PAGE_BUTTON  = 8'h09;
    localparam logic [7:0] USAGE_X      = 8'h30;
    localparam logic [7:0] USAGE_HAT    = 8'h39;

    localparam logic [OUT_OFF_W-1:0] HAT_NONE = '1;

    // One short item ready to act, as produced by the byte framer
    typedef struct packed {
        logic       act;
        logic [1:0] itype;
        logic [3:0] tag;
        logic [7:0] val;
    } hgp_item_t;

    // Located fields reported at the end of a descriptor
    typedef struct packed {
        logic                 found;
        logic                 has_report_id;
        logic [7:0]           gamepad_report;
        logic [OUT_OFF_W-1:0] stick_offset;
        logic                 hat_present;
        logic [OUT_OFF_W-1:0] hat_offset;
        logic [OUT_OFF_W-1:0] button_offset;
        logic [7:0]           button_count;
    } hgp_result_t;

endpackage

FILE: hw/rtl/hgp_if.sv
// Interfaces: descriptor byte channel and located-field result channel.
`timescale 1ns / 1ps

interface hgp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] desc_byte;
    logic       last_byte;

    modport source (output valid, output desc_byte, output last_byte, input ready);
    modport sink   (input valid, input desc_byte, input last_byte, output ready);
endinterface

interface hgp_result_if;
    logic        valid;
    logic        ready;
    logic        found;
    logic        has_report_id;
    logic [7:0]  gamepad_report;
    logic [15:0] stick_offset;
    logic        hat_present;
    logic [15:0] hat_offset;
    logic [15:0] button_offset;
    logic [7:0]  button_count;

    modport source (output valid, output found, output has_report_id, output gamepad_report,
                    output stick_offset, output hat_present, output hat_offset,
                    output button_offset, output button_count, input ready);
    modport sink   (input valid, input found, input has_report_id, input gamepad_report,
                    input stick_offset, input hat_present, input hat_offset,
                    input button_offset, input button_count, output ready);
endinterface

FILE: hw/rtl/hid_gamepad_descriptor_parser_core.sv
// Top level: HID report descriptor parser that locates gamepad stick, hat and button fields.
`timescale 1ns / 1ps

// Descriptor bytes enter on the desc channel, one transfer per byte, and pass through an
// input register; the short-item decode, the parse-state update and the offset advance
// (report size times report count, an 8x8 multiply and an add) all close as the byte leaves
// that register, so the block sustains one byte per clock. A transfer with last_byte set
// produces exactly one result transfer, by way of the input register and the output register;
// other bytes produce none. The result sits in the output register, so bytes that are not last
// keep flowing while a result waits; only a second last byte holds in the input register until
// the waiting result is taken. After the last byte the parse state returns to its reset values,
// while the located stick, hat and button fields persist into the next descriptor. Offsets are
// counted modulo 2**OFFSET_WIDTH and reported in their low 16 bits; hat_offset reads all ones
// until a hat switch field has been located.
module hid_gamepad_descriptor_parser_core (
    input  logic           clk,
    input  logic           rst_n,
    hgp_byte_if.sink       desc,
    hgp_result_if.source   result
);
    import hgp_pkg::*;

    // input register
    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       in_last_reg;
    logic       advance;

    // parse state
    logic                    page_ok_reg, page_ok_next;
    logic [7:0]              page_reg, page_next;
    logic                    usage_ok_reg, usage_ok_next;
    logic [7:0]              usage_reg, usage_next;
    logic [7:0]              size_reg, size_next;
    logic [7:0]              count_reg, count_next;
    logic                    id_ok_reg, id_ok_next;
    logic [7:0]              id_reg, id_next;
    logic [OFFSET_WIDTH-1:0] offset_reg, offset_next;
    logic                    any_found_reg, any_found_next;

    // located fields
    logic                 loc_has_id_reg, loc_has_id_next;
    logic [7:0]           loc_report_reg, loc_report_next;
    logic [OUT_OFF_W-1:0] loc_stick_reg, loc_stick_next;
    logic                 loc_hat_ok_reg, loc_hat_ok_next;
    logic [OUT_OFF_W-1:0] loc_hat_reg, loc_hat_next;
    logic [OUT_OFF_W-1:0] loc_btn_reg, loc_btn_next;
    logic [7:0]           loc_btn_count_reg, loc_btn_count_next;

    // output register
    logic        out_valid_reg;
    hgp_result_t result_reg, result_next;

    hgp_item_t        item;
    logic [15:0]      field_bits;
    logic             is_desktop;

    // Only a last byte needs room in the output register
    assign advance   = in_valid_reg && (!in_last_reg || !out_valid_reg || result.ready);
    assign desc.ready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            in_last_reg  <= 1'b0;
        end
        else if (desc.ready)
        begin
            in_valid_reg <= desc.valid;
            in_last_reg  <= desc.last_byte;
        end
    end

    always_ff @(posedge clk)
    begin
        if (desc.ready && desc.valid)
        begin
            in_byte_reg <= desc.desc_byte;
        end
    end

    hgp_item_framer u_framer (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (advance),
        .byte_in (in_byte_reg),
        .last    (in_last_reg),
        .item    (item)
    );

    assign field_bits = size_reg * count_reg;
    assign is_desktop = page_ok_reg && (page_reg == PAGE_DESKTOP);

    // Apply one item to the parse state and the located fields
    always_comb
    begin
        page_ok_next       = page_ok_reg;
        page_next          = page_reg;
        usage_ok_next      = usage_ok_reg;
        usage_next         = usage_reg;
        size_next          = size_reg;
        count_next         = count_reg;
        id_ok_next         = id_ok_reg;
        id_next            = id_reg;
        offset_next        = offset_reg;
        any_found_next     = any_found_reg;
        loc_has_id_next    = loc_has_id_reg;
        loc_report_next    = loc_report_reg;
        loc_stick_next     = loc_stick_reg;
        loc_hat_ok_next    = loc_hat_ok_reg;
        loc_hat_next       = loc_hat_reg;
        loc_btn_next       = loc_btn_reg;
        loc_btn_count_next = loc_btn_count_reg;

        if (item.act)
        begin
            case (item.itype)
                TYPE_MAIN:
                begin
                    case (item.tag)
                        TAG_INPUT:
                        begin
                            if (is_desktop && usage_ok_reg && usage_reg == USAGE_X)
                            begin
                                loc_stick_next  = OUT_OFF_W'(offset_reg);
                                loc_has_id_next = id_ok_reg;
                                loc_report_next = id_ok_reg ? id_reg : 8'h00;
                                any_found_next  = 1'b1;
                            end
                            else if (is_desktop && usage_ok_reg && usage_reg == USAGE_HAT)
                            begin
                                loc_hat_next    = OUT_OFF_W'(offset_reg);
                                loc_hat_ok_next = 1'b1;
                                any_found_next  = 1'b1;
                            end
                            else if (page_ok_reg && page_reg == PAGE_BUTTON && !item.val[0])
                            begin
                                // non-constant button field
                                loc_btn_next       = OUT_OFF_W'(offset_reg);
                                loc_btn_count_next = count_reg;
                                any_found_next     = 1'b1;
                            end
                            usage_ok_next = 1'b0;
                            offset_next   = offset_reg + OFFSET_WIDTH'(field_bits);
                        end
                        TAG_COLLECTION:
                        begin
                            usage_ok_next = 1'b0;
                        end
                        default:
                        begin
                        end
                    endcase
                end
                TYPE_GLOBAL:
                begin
                    case (item.tag)
                        TAG_USAGE_PAGE:
                        begin
                            page_next    = item.val;
                            page_ok_next = 1'b1;
                        end
                        TAG_REPORT_SIZE:
                        begin
                            size_next = item.val;
                        end
                        TAG_REPORT_ID:
                        begin
                            // offsets restart within each report
                            id_next     = item.val;
                            id_ok_next  = 1'b1;
                            offset_next = '0;
                        end
                        TAG_REPORT_COUNT:
                        begin
                            count_next = item.val;
                        end
                        default:
                        begin
                        end
                    endcase
                end
                TYPE_LOCAL:
                begin
                    // keep only the first usage before the next Input or Collection item
                    if (item.tag == TAG_USAGE && !usage_ok_reg)
                    begin
                        usage_next    = item.val;
                        usage_ok_next = 1'b1;
                    end
                end
                default:
                begin
                end
            endcase
        end

        result_next.found          = any_found_next;
        result_next.has_report_id  = loc_has_id_next;
        result_next.gamepad_report = loc_report_next;
        result_next.stick_offset   = loc_stick_next;
        result_next.hat_present    = loc_hat_ok_next;
        result_next.hat_offset     = loc_hat_ok_next ? loc_hat_next : HAT_NONE;
        result_next.button_offset  = loc_btn_next;
        result_next.button_count   = loc_btn_count_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            page_ok_reg       <= 1'b0;
            page_reg          <= 8'h00;
            usage_ok_reg      <= 1'b0;
            usage_reg         <= 8'h00;
            size_reg          <= 8'h00;
            count_reg         <= 8'h00;
            id_ok_reg         <= 1'b0;
            id_reg            <= 8'h00;
            offset_reg        <= '0;
            any_found_reg     <= 1'b0;
            loc_has_id_reg    <= 1'b0;
            loc_report_reg    <= 8'h00;
            loc_stick_reg     <= '0;
            loc_hat_ok_reg    <= 1'b0;
            loc_hat_reg       <= HAT_NONE;
            loc_btn_reg       <= '0;
            loc_btn_count_reg <= 8'h00;
        end
        else if (advance)
        begin
            // located fields persist across descriptors
            loc_has_id_reg    <= loc_has_id_next;
            loc_report_reg    <= loc_report_next;
            loc_stick_reg     <= loc_stick_next;
            loc_hat_ok_reg    <= loc_hat_ok_next;
            loc_hat_reg       <= loc_hat_next;
            loc_btn_reg       <= loc_btn_next;
            loc_btn_count_reg <= loc_btn_count_next;
            if (in_last_reg)
            begin
                // drop the parse state for the next descriptor
                page_ok_reg   <= 1'b0;
                page_reg      <= 8'h00;
                usage_ok_reg  <= 1'b0;
                usage_reg     <= 8'h00;
                size_reg      <= 8'h00;
                count_reg     <= 8'h00;
                id_ok_reg     <= 1'b0;
                id_reg        <= 8'h00;
                offset_reg    <= '0;
                any_found_reg <= 1'b0;
            end
            else
            begin
                page_ok_reg   <= page_ok_next;
                page_reg      <= page_next;
                usage_ok_reg  <= usage_ok_next;
                usage_reg     <= usage_next;
                size_reg      <= size_next;
                count_reg     <= count_next;
                id_ok_reg     <= id_ok_next;
                id_reg        <= id_next;
                offset_reg    <= offset_next;
                any_found_reg <= any_found_next;
            end
        end
    end

    // Output register: hold the result until its transfer completes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance && in_last_reg)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && in_last_reg)
        begin
            result_reg <= result_next;
        end
    end

    assign result.valid          = out_valid_reg;
    assign result.found          = result_reg.found;
    assign result.has_report_id  = result_reg.has_report_id;
    assign result.gamepad_report = result_reg.gamepad_report;
    assign result.stick_offset   = result_reg.stick_offset;
    assign result.hat_present    = result_reg.hat_present;
    assign result.hat_offset     = result_reg.hat_offset;
    assign result.button_offset  = result_reg.button_offset;
    assign result.button_count   = result_reg.button_count;

endmodule

FILE: hw/rtl/hgp_item_framer.sv
// Item framer: splits short item headers from data bytes and releases at most one item per byte.
`timescale 1ns / 1ps

module hgp_item_framer (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic [7:0]        byte_in,
    input  logic              last,
    output hgp_pkg::hgp_item_t item
);
    import hgp_pkg::*;

    logic [2:0] data_left_reg, data_left_next;
    logic [1:0] type_reg, type_next;
    logic [3:0] tag_reg, tag_next;
    logic       pending_reg, pending_next;
    logic [2:0] len;

    assign len = (byte_in[1:0] == SIZE_CODE_FOUR) ? 3'd4 : {1'b0, byte_in[1:0]};

    always_comb
    begin
        data_left_next = data_left_reg;
        type_next      = type_reg;
        tag_next       = tag_reg;
        pending_next   = pending_reg;
        item           = '0;
        if (data_left_reg != 3'd0)
        begin
            // first data byte carries the value; later ones are dropped
            item.act       = pending_reg;
            item.itype     = type_reg;
            item.tag       = tag_reg;
            item.val       = byte_in;
            pending_next   = 1'b0;
            data_left_next = data_left_reg - 3'd1;
        end
        else
        begin
            // header: act now if no data follows, or if the descriptor ends here
            item.act   = (len == 3'd0) || last;
            item.itype = byte_in[3:2];
            item.tag   = byte_in[7:4];
            item.val   = 8'h00;
            if (len != 3'd0)
            begin
                type_next      = byte_in[3:2];
                tag_next       = byte_in[7:4];
                pending_next   = 1'b1;
                data_left_next = len;
            end
        end
        if (last)
        begin
            data_left_next = 3'd0;
            type_next      = 2'd0;
            tag_next       = 4'd0;
            pending_next   = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            data_left_reg <= 3'd0;
            type_reg      <= 2'd0;
            tag_reg       <= 4'd0;
            pending_reg   <= 1'b0;
        end
        else if (en)
        begin
            data_left_reg <= data_left_next;
            type_reg      <= type_next;
            tag_reg       <= tag_next;
            pending_reg   <= pending_next;
        end
    end

endmodule

FILE: sim/hid_gamepad_descriptor_parser_core_tb.sv
// Testbench for the HID gamepad descriptor parser: directed and random descriptors, checked per result.
`timescale 1ns / 1ps

// Descriptor bytes are sent one transfer at a time. A short-item parser in this file follows
// every accepted byte. On the byte marked last it queues the located fields that the block
// must report. A separate process takes each result transfer and compares it, field by field,
// with the oldest queued entry. Both channels idle at random. One test holds the result side
// off long enough to stall the input. Another pauses the sender until all results are in.
module hid_gamepad_descriptor_parser_core_tb;
    import hgp_pkg::*;

    localparam int CLK_HALF       = 4;
    localparam int RESET_CYCLES   = 6;
    localparam int TARGET_BYTES   = 450;
    localparam int STALL_CYCLES   = 150;
    localparam int DRAIN_CYCLES   = 6;
    localparam int WATCHDOG_LIMIT = 2000;

    // Item codes that the package does not name
    localparam logic [1:0] TYPE_RESERVED      = 2'd3;
    localparam logic [3:0] TAG_END_COLLECTION = 4'hC;
    localparam logic [3:0] TAG_LONG_ITEM      = 4'hF;
    localparam logic [3:0] TAG_USAGE_MIN      = 4'h1;
    localparam logic [1:0] SIZE_CODE_ZERO     = 2'd0;
    localparam logic [1:0] SIZE_CODE_ONE      = 2'd1;
    localparam logic [1:0] SIZE_CODE_TWO      = 2'd2;
    localparam logic [7:0] USAGE_Y            = 8'h31;
    localparam logic [7:0] USAGE_GAMEPAD      = 8'h05;
    localparam logic [7:0] COLL_APPLICATION   = 8'h01;
    localparam logic [7:0] FIRST_BUTTON       = 8'h01;
    localparam logic [7:0] INPUT_DATA_VAR     = 8'h02;
    localparam logic [7:0] INPUT_CONST        = 8'h03;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    hgp_byte_if   desc_ch();
    hgp_result_if res_ch();

    hid_gamepad_descriptor_parser_core dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .desc   (desc_ch),
        .result (res_ch)
    );

    always
    begin
        #CLK_HALF clk = 1'b1;
        #CLK_HALF clk = 1'b0;
    end

    // Parse state of the descriptor in progress
    logic [2:0]              bytes_owed;
    logic [1:0]              held_type;
    logic [3:0]              held_tag;
    logic                    held_waiting;
    logic                    page_set;
    logic [7:0]              page_cur;
    logic                    usage_set;
    logic [7:0]              usage_cur;
    logic [7:0]              size_cur;
    logic [7:0]              count_cur;
    logic                    id_set;
    logic [7:0]              id_cur;
    logic [OFFSET_WIDTH-1:0] bit_pos;
    logic                    hit_this_desc;

    // Located fields; these survive from one descriptor to the next
    logic                    stick_has_id;
    logic [7:0]              stick_report;
    logic [OFFSET_WIDTH-1:0] stick_pos;
    logic                    hat_seen;
    logic [OFFSET_WIDTH-1:0] hat_pos;
    logic [OFFSET_WIDTH-1:0] button_pos;
    logic [7:0]              button_bits;

    hgp_result_t located_q[$];   // located fields owed by the block, oldest first
    logic [7:0]  frame[$];       // descriptor being built for sending

    int n_bytes     = 0;
    int n_reports   = 0;
    int n_checked   = 0;
    int n_errors    = 0;
    int idle_cycles = 0;
    int sink_hold   = 0;
    bit src_steady  = 1'b0;
    bit sink_steady = 1'b0;

    // ------------------------------------------------------------------
    // Descriptor parser used for prediction
    // ------------------------------------------------------------------

    function automatic void clear_parse_state();
        bytes_owed    = '0;
        held_type     = '0;
        held_tag      = '0;
        held_waiting  = 1'b0;
        page_set      = 1'b0;
        page_cur      = '0;
        usage_set     = 1'b0;
        usage_cur     = '0;
        size_cur      = '0;
        count_cur     = '0;
        id_set        = 1'b0;
        id_cur        = '0;
        bit_pos       = '0;
        hit_this_desc = 1'b0;
    endfunction

    function automatic void clear_located();
        stick_has_id = 1'b0;
        stick_report = '0;
        stick_pos    = '0;
        hat_seen     = 1'b0;
        hat_pos      = '1;
        button_pos   = '0;
        button_bits  = '0;
    endfunction

    // Act on one short item with its value (first data byte, or zero)
    function automatic void apply_item(logic [1:0] itype, logic [3:0] tag, logic [7:0] val);
        logic [15:0] field_bits;
        field_bits = 16'(size_cur) * 16'(count_cur);
        case (itype)
            TYPE_MAIN:
            begin
                if (tag == TAG_INPUT)
                begin
                    // Stick wins over hat, hat over buttons; a constant field is padding
                    if (page_set && page_cur == PAGE_DESKTOP && usage_set && usage_cur == USAGE_X)
                    begin
                        stick_pos     = bit_pos;
                        stick_has_id  = id_set;
                        stick_report  = id_set ? id_cur : 8'h00;
                        hit_this_desc = 1'b1;
                    end
                    else if (page_set && page_cur == PAGE_DESKTOP && usage_set
                             && usage_cur == USAGE_HAT)
                    begin
                        hat_pos       = bit_pos;
                        hat_seen      = 1'b1;
                        hit_this_desc = 1'b1;
                    end
                    else if (page_set && page_cur == PAGE_BUTTON && !val[0])
                    begin
                        button_pos    = bit_pos;
                        button_bits   = count_cur;
                        hit_this_desc = 1'b1;
                    end
                    usage_set = 1'b0;
                    bit_pos   = bit_pos + OFFSET_WIDTH'(field_bits);
                end
                else if (tag == TAG_COLLECTION)
                begin
                    usage_set = 1'b0;
                end
            end
            TYPE_GLOBAL:
            begin
                if (tag == TAG_USAGE_PAGE)
                begin
                    page_cur = val;
                    page_set = 1'b1;
                end
                else if (tag == TAG_REPORT_SIZE)
                begin
                    size_cur = val;
                end
                else if (tag == TAG_REPORT_ID)
                begin
                    id_cur  = val;
                    id_set  = 1'b1;
                    bit_pos = '0;
                end
                else if (tag == TAG_REPORT_COUNT)
                begin
                    count_cur = val;
                end
            end
            TYPE_LOCAL:
            begin
                // Only the first usage before an Input or Collection item counts
                if (tag == TAG_USAGE && !usage_set)
                begin
                    usage_cur = val;
                    usage_set = 1'b1;
                end
            end
            default:
            begin
                // Reserved and long items: their data is skipped by size code alone
            end
        endcase
    endfunction

    // Advance the parser by one accepted byte; queue the located fields on the last byte
    function automatic void parse_desc_byte(logic [7:0] b, logic is_last);
        logic [2:0]  len;
        hgp_result_t located;
        if (bytes_owed != 0)
        begin
            if (held_waiting)
            begin
                apply_item(held_type, held_tag, b);
                held_waiting = 1'b0;
            end
            bytes_owed = bytes_owed - 3'd1;
        end
        else
        begin
            len = (b[1:0] == SIZE_CODE_FOUR) ? 3'd4 : {1'b0, b[1:0]};
            if (len == 0)
            begin
                apply_item(b[3:2], b[7:4], 8'h00);
            end
            else
            begin
                held_type    = b[3:2];
                held_tag     = b[7:4];
                held_waiting = 1'b1;
                bytes_owed   = len;
            end
        end
        if (is_last)
        begin
            // An item still short of its first data byte acts with value zero
            if (held_waiting)
            begin
                apply_item(held_type, held_tag, 8'h00);
                held_waiting = 1'b0;
            end
            located.found          = hit_this_desc;
            located.has_report_id  = stick_has_id;
            located.gamepad_report = stick_report;
            located.stick_offset   = OUT_OFF_W'(stick_pos);
            located.hat_present    = hat_seen;
            located.hat_offset     = hat_seen ? OUT_OFF_W'(hat_pos) : HAT_NONE;
            located.button_offset  = OUT_OFF_W'(button_pos);
            located.button_count   = button_bits;
            located_q.push_back(located);
            n_reports++;
            clear_parse_state();
        end
    endfunction

    // ------------------------------------------------------------------
    // Descriptor building
    // ------------------------------------------------------------------

    function automatic void put_item_sized(logic [1:0] itype, logic [3:0] tag, logic [7:0] val,
                                           logic [1:0] code);
        int n;
        n = (code == SIZE_CODE_FOUR) ? 4 : int'(code);
        frame.push_back({tag, itype, code});
        if (n > 0)
            frame.push_back(val);
        // Only the first data byte matters; fill the rest with junk
        for (int i = 1; i < n; i++)
            frame.push_back(8'($urandom));
    endfunction

    // Pick a size code at random: mostly one byte, sometimes two or four, rarely none
    function automatic void put_item(logic [1:0] itype, logic [3:0] tag, logic [7:0] val);
        int         r;
        logic [1:0] code;
        r = $urandom_range(0, 99);
        if (r < 6 || (val == 8'h00 && r < 30))
            code = SIZE_CODE_ZERO;
        else if (r < 80)
            code = SIZE_CODE_ONE;
        else if (r < 90)
            code = SIZE_CODE_TWO;
        else
            code = SIZE_CODE_FOUR;
        put_item_sized(itype, tag, val, code);
    endfunction

    // Report size or count: small as a rule, anything up to the byte limit now and then
    function automatic logic [7:0] pick_field_len();
        if ($urandom_range(0, 99) < 85)
            return 8'($urandom_range(1, 16));
        return 8'($urandom);
    endfunction

    function automatic void build_noise_descriptor();
        frame.delete();
        repeat ($urandom_range(1, 16))
            frame.push_back(8'($urandom));
    endfunction

    // Well-formed gamepad-like descriptor with random field mix, sizes and size codes
    function automatic void build_gamepad_descriptor();
        int         kind;
        int         extra;
        logic [7:0] input_flags;
        frame.delete();
        if ($urandom_range(0, 1))
        begin
            put_item(TYPE_GLOBAL, TAG_USAGE_PAGE, PAGE_DESKTOP);
            put_item(TYPE_LOCAL, TAG_USAGE, USAGE_GAMEPAD);
            put_item(TYPE_MAIN, TAG_COLLECTION, COLL_APPLICATION);
        end
        if ($urandom_range(0, 2) == 0)
            put_item(TYPE_GLOBAL, TAG_REPORT_ID, 8'($urandom));
        repeat ($urandom_range(1, 4))
        begin
            kind        = $urandom_range(0, 7);
            input_flags = ($urandom_range(0, 4) == 0) ? 8'($urandom) : INPUT_DATA_VAR;
            case (kind)
                0, 1:
                begin
                    // Stick; a Y usage ahead of X hides the X
                    if ($urandom_range(0, 3) != 0)
                        put_item(TYPE_GLOBAL, TAG_USAGE_PAGE, PAGE_DESKTOP);
                    if ($urandom_range(0, 3) == 0)
                        put_item(TYPE_LOCAL, TAG_USAGE, USAGE_Y);
                    put_item(TYPE_LOCAL, TAG_USAGE, USAGE_X);
                    if ($urandom_range(0, 2) == 0)
                        put_item(TYPE_LOCAL, TAG_USAGE, USAGE_Y);
                end
                2:
                begin
                    if ($urandom_range(0, 3) != 0)
                        put_item(TYPE_GLOBAL, TAG_USAGE_PAGE, PAGE_DESKTOP);
                    put_item(TYPE_LOCAL, TAG_USAGE, USAGE_HAT);
                end
                3:
                begin
                    put_item(TYPE_GLOBAL, TAG_USAGE_PAGE, PAGE_BUTTON);
                    put_item(TYPE_LOCAL, TAG_USAGE_MIN, FIRST_BUTTON);
                end
                4:
                begin
                    input_flags = INPUT_CONST;
                end
                5:
                begin
                    put_item(TYPE_GLOBAL, TAG_USAGE_PAGE, 8'($urandom));
                    put_item(TYPE_LOCAL, TAG_USAGE, 8'($urandom));
                end
                6:
                begin
                    put_item(TYPE_GLOBAL, TAG_REPORT_ID, 8'($urandom));
                end
                default:
                begin
                    extra = $urandom_range(0, 2);
                    if (extra == 0)
                        put_item(TYPE_MAIN, TAG_COLLECTION, COLL_APPLICATION);
                    else if (extra == 1)
                        put_item_sized(TYPE_MAIN, TAG_END_COLLECTION, 8'h00, SIZE_CODE_ZERO);
                    else
                        put_item(TYPE_RESERVED, 4'($urandom), 8'($urandom));
                end
            endcase
            if ($urandom_range(0, 4) != 0)
                put_item(TYPE_GLOBAL, TAG_REPORT_SIZE, pick_field_len());
            if ($urandom_range(0, 4) != 0)
                put_item(TYPE_GLOBAL, TAG_REPORT_COUNT, pick_field_len());
            if (kind < 6)
                put_item(TYPE_MAIN, TAG_INPUT, input_flags);
        end
        if ($urandom_range(0, 1))
            put_item_sized(TYPE_MAIN, TAG_END_COLLECTION, 8'h00, SIZE_CODE_ZERO);
        // Now and then cut the descriptor short, possibly mid-item
        if ($urandom_range(0, 7) == 0)
        begin
            repeat ($urandom_range(1, 3))
                if (frame.size() > 1)
                    void'(frame.pop_back());
        end
    endfunction

    // ------------------------------------------------------------------
    // Channel drivers
    // ------------------------------------------------------------------

    // Idle length: mostly none or short, a few long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 82)
            return $urandom_range(1, 3);
        if (r < 96)
            return $urandom_range(4, 12);
        return $urandom_range(20, 45);
    endfunction

    // Offer one byte, hold it until the transfer, then feed it to the parser
    task automatic send_byte(logic [7:0] b, logic is_last);
        int gap;
        gap = src_steady ? 0 : pick_gap();
        if (gap > 0)
        begin
            desc_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        desc_ch.valid     <= 1'b1;
        desc_ch.desc_byte <= b;
        desc_ch.last_byte <= is_last;
        do
            @(posedge clk);
        while (desc_ch.ready !== 1'b1);
        parse_desc_byte(b, is_last);
        n_bytes++;
    endtask

    task automatic send_descriptor();
        for (int i = 0; i < frame.size(); i++)
            send_byte(frame[i], i == frame.size() - 1);
    endtask

    // Drop valid and hold until every owed result has been taken
    task automatic wait_results_drained();
        desc_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (located_q.size() != 0);
    endtask

    // Result side: random stalls, or a long hold counted down here when a test asks
    initial
    begin : result_sink
        int gap;
        gap          = 0;
        res_ch.ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (sink_hold > 0)
            begin
                sink_hold--;
                res_ch.ready <= 1'b0;
            end
            else if (gap > 0)
            begin
                gap--;
                res_ch.ready <= 1'b0;
            end
            else if (!sink_steady && $urandom_range(0, 3) == 0)
            begin
                gap = pick_gap();
                res_ch.ready <= 1'b0;
            end
            else
            begin
                res_ch.ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Result checking and watchdog
    // ------------------------------------------------------------------

    function automatic void check_field(string what, logic [15:0] want, logic [15:0] got);
        if (got !== want)
        begin
            $display("%0t ns: %s mismatch, expected %h actual %h", $time, what, want, got);
            n_errors++;
        end
    endfunction

    always @(posedge clk)
    begin : located_check
        hgp_result_t want;
        if (rst_n && res_ch.valid === 1'b1 && res_ch.ready === 1'b1)
        begin
            if (located_q.size() == 0)
            begin
                $display("%0t ns: result transfer with no descriptor end pending", $time);
                n_errors++;
            end
            else
            begin
                want = located_q.pop_front();
                check_field("found", want.found, res_ch.found);
                check_field("has_report_id", want.has_report_id, res_ch.has_report_id);
                check_field("gamepad_report", want.gamepad_report, res_ch.gamepad_report);
                check_field("stick_offset", want.stick_offset, res_ch.stick_offset);
                check_field("hat_present", want.hat_present, res_ch.hat_present);
                check_field("hat_offset", want.hat_offset, res_ch.hat_offset);
                check_field("button_offset", want.button_offset, res_ch.button_offset);
                check_field("button_count", want.button_count, res_ch.button_count);
                n_checked++;
            end
        end
    end

    // End the run if neither channel moves for too long
    always @(posedge clk)
    begin : watchdog
        if (rst_n)
        begin
            if ((desc_ch.valid === 1'b1 && desc_ch.ready === 1'b1)
                || (res_ch.valid === 1'b1 && res_ch.ready === 1'b1))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("%0t ns: no transfer for %0d cycles, %0d results outstanding",
                         $time, idle_cycles, located_q.size());
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Zero-size item alone, a long item cut before its data, 0xFF alone,
    // and a four-byte report size cut after its first data byte
    task automatic test_empty_and_reserved();
        frame.delete();
        put_item_sized(TYPE_MAIN, TAG_END_COLLECTION, 8'h00, SIZE_CODE_ZERO);
        send_descriptor();
        frame.delete();
        put_item_sized(TYPE_RESERVED, TAG_LONG_ITEM, 8'h02, SIZE_CODE_TWO);
        repeat (2) void'(frame.pop_back());
        send_descriptor();
        frame.delete();
        put_item_sized(TYPE_RESERVED, TAG_LONG_ITEM, 8'hFF, SIZE_CODE_FOUR);
        repeat (4) void'(frame.pop_back());
        send_descriptor();
        frame.delete();
        put_item_sized(TYPE_GLOBAL, TAG_REPORT_SIZE, 8'h10, SIZE_CODE_FOUR);
        repeat (3) void'(frame.pop_back());
        send_descriptor();
    endtask

    // Stick with report id, hat after a 255x255 field, constant padding that wraps the offset,
    // button page given with four data bytes, and a final Input whose data byte never comes
    task automatic test_stick_hat_buttons();
        frame.delete();
        put_item_sized(TYPE_GLOBAL, TAG_USAGE_PAGE, PAGE_DESKTOP, SIZE_CODE_ONE);
        put_item_sized(TYPE_GLOBAL, TAG_REPORT_ID, 8'h07, SIZE_CODE_ONE);
        put_item_sized(TYPE_LOCAL, TAG_USAGE, USAGE_X, SIZE_CODE_ONE);
        put_item_sized(TYPE_GLOBAL, TAG_REPORT_SIZE, 8'hFF, SIZE_CODE_ONE);
        put_item_sized(TYPE_GLOBAL, TAG_REPORT_COUNT, 8'hFF, SIZE_CODE_ONE);
        put_item_sized(TYPE_MAIN, TAG_INPUT, INPUT_DATA_VAR, SIZE_CODE_ONE);
        put_item_sized(TYPE_LOCAL, TAG_USAGE, USAGE_HAT, SIZE_CODE_ONE);
        put_item_sized(TYPE_MAIN, TAG_INPUT, INPUT_DATA_VAR, SIZE_CODE_ONE);
        put_item_sized(TYPE_GLOBAL, TAG_USAGE_PAGE, PAGE_BUTTON, SIZE_CODE_FOUR);
        put_item_sized(TYPE_MAIN, TAG_INPUT, INPUT_CONST, SIZE_CODE_ONE);
        put_item_sized(TYPE_GLOBAL, TAG_REPORT_SIZE, 8'h01, SIZE_CODE_ONE);
        put_item_sized(TYPE_GLOBAL, TAG_REPORT_COUNT, 8'h0C, SIZE_CODE_ONE);
        put_item_sized(TYPE_MAIN, TAG_INPUT, INPUT_DATA_VAR, SIZE_CODE_ONE);
        void'(frame.pop_back());
        send_descriptor();
    endtask

    // Hold the result side off while short descriptors keep coming, so the block backs up
    task automatic test_output_backpressure();
        sink_hold  = STALL_CYCLES;
        src_steady = 1'b1;
        repeat (12)
        begin
            build_noise_descriptor();
            while (frame.size() > 3)
                void'(frame.pop_back());
            send_descriptor();
        end
        src_steady = 1'b0;
        wait_results_drained();
    endtask

    // Let the block go fully idle between descriptors
    task automatic test_pause_and_resume();
        repeat (3)
        begin
            build_gamepad_descriptor();
            send_descriptor();
            wait_results_drained();
        end
    endtask

    // Mostly well-formed descriptors, some pure noise; switch idling on and off per descriptor
    task automatic test_random_descriptors();
        while (n_bytes < TARGET_BYTES)
        begin
            src_steady  = ($urandom_range(0, 5) == 0);
            sink_steady = ($urandom_range(0, 5) == 0);
            if ($urandom_range(0, 4) == 0)
                build_noise_descriptor();
            else
                build_gamepad_descriptor();
            send_descriptor();
        end
        src_steady  = 1'b0;
        sink_steady = 1'b0;
    endtask

    initial
    begin : main_seq
        desc_ch.valid     = 1'b0;
        desc_ch.desc_byte = 8'h00;
        desc_ch.last_byte = 1'b0;
        clear_parse_state();
        clear_located();
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_and_reserved();
        test_stick_hat_buttons();
        test_output_backpressure();
        test_pause_and_resume();
        test_random_descriptors();

        // Drain, then give a stray extra result time to show up
        wait_results_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d descriptor bytes in %0d descriptors; checked %0d results, %0d mismatches.",
                 n_bytes, n_reports, n_checked, n_errors);
        $display("Covered reserved and long items, four-byte and missing data, offset wrap, %s",
                 "report ids, noise descriptors and a long result-side stall.");
        if (n_errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

FILE: files.f
hw/rtl/hgp_pkg.sv
hw/rtl/hgp_if.sv
hw/rtl/hgp_item_framer.sv
hw/rtl/hid_gamepad_descriptor_parser_core.sv
sim/hid_gamepad_descriptor_parser_core_tb.sv
